### hdl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg: shared types and constants of the per-source flood detector
// Holds the token that travels down the cell chain, the configuration
// bundle and the entry write bundle.
// ----------------------------------------------------------------------------
package pfd_pkg;

	localparam int ADDR_W  = 32;
	localparam int TIME_W  = 48;
	localparam int CNT_W   = 16;
	localparam int WIN_W   = 36;
	localparam int SPAN_W  = 49;
	localparam int IN_W    = 80;
	localparam int OUT_W   = 200;

	localparam logic [19:0]      US_PER_S      = 20'd1000000;
	localparam logic [CNT_W-1:0] CNT_MAX       = '1;
	localparam logic [CNT_W-1:0] THR_RESET     = 16'd100;
	localparam logic [WIN_W-1:0] WIN_US_RESET  = 36'd1000000;

	typedef enum logic {
		REG_ALERT_THRESHOLD = 1'b0,
		REG_WINDOW_LENGTH_S = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] thr;
		logic [WIN_W-1:0] win_us;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic              found;
		logic              alert;
		logic [ADDR_W-1:0] src;
		logic [TIME_W-1:0] ts;
		logic [CNT_W-1:0]  cnt;
		logic [TIME_W-1:0] first;
	} tok_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] src;
		logic [CNT_W-1:0]  cnt;
		logic [TIME_W-1:0] wstart;
	} wr_t;

endpackage

### hdl/pfd_cell.sv
// ----------------------------------------------------------------------------
// pfd_cell: one source entry of the flood detector table
// Holds address, count and window start of one entry. A lookup token passes
// through once per packet; the first active cell that matches updates itself
// and marks the token as found.
// ----------------------------------------------------------------------------
module pfd_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  pfd_pkg::cfg_t  cfg,
	input  logic           active,
	input  logic           wr_sel,
	input  pfd_pkg::wr_t   wr,
	input  pfd_pkg::tok_t  tok_in,
	output pfd_pkg::tok_t  tok_out
);
	import pfd_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] wstart_q;

	logic              tok_valid_q;
	logic              tok_found_q;
	logic              tok_alert_q;
	logic [ADDR_W-1:0] tok_src_q;
	logic [TIME_W-1:0] tok_ts_q;
	logic [CNT_W-1:0]  tok_cnt_q;
	logic [TIME_W-1:0] tok_first_q;

	logic              hit;
	logic [SPAN_W-1:0] diff;
	logic              expired;
	logic [CNT_W-1:0]  cnt_base;
	logic [CNT_W-1:0]  cnt_new;
	logic [TIME_W-1:0] wst;
	logic              alert;

	always_comb begin
		hit      = tok_in.valid && !tok_in.found && active && (addr_q == tok_in.src);
		diff     = {1'b0, tok_in.ts} - {1'b0, wstart_q};
		expired  = $signed(diff) > $signed({{(SPAN_W-WIN_W){1'b0}}, cfg.win_us});
		cnt_base = expired ? '0 : count_q;
		cnt_new  = (cnt_base == CNT_MAX) ? CNT_MAX : cnt_base + 1'b1;
		wst      = expired ? tok_in.ts : wstart_q;
		alert    = cnt_new >= cfg.thr;
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr_sel) begin
			addr_q   <= wr.src;
			count_q  <= wr.cnt;
			wstart_q <= wr.wstart;
		end else if (hit) begin
			count_q  <= alert ? '0 : cnt_new;
			wstart_q <= alert ? tok_in.ts : wst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_src_q <= tok_in.src;
		tok_ts_q  <= tok_in.ts;
		if (hit) begin
			tok_found_q <= 1'b1;
			tok_alert_q <= alert;
			tok_cnt_q   <= cnt_new;
			tok_first_q <= wst;
		end else begin
			tok_found_q <= tok_in.found;
			tok_alert_q <= tok_in.alert;
			tok_cnt_q   <= tok_in.cnt;
			tok_first_q <= tok_in.first;
		end
	end

	assign tok_out = {tok_valid_q, tok_found_q, tok_alert_q, tok_src_q, tok_ts_q,
		tok_cnt_q, tok_first_q};

endmodule

### hdl/per_source_flood_detector.sv
// ----------------------------------------------------------------------------
// per_source_flood_detector: per-source fixed-window packet rate alerting
// Counts packets per source address in fixed time windows and reports
// sources whose count reaches a programmable threshold.
// ----------------------------------------------------------------------------
// Packets enter on the s_ stream; one result per packet leaves on the m_
// stream, with m_tuser high when the packet raised an alert. The user must
// write the two registers through cfg_we, cfg_index and cfg_data only while the
// block is idle; the block itself does not enforce this.
// The table is a chain of MAX_SOURCES cells. A lookup token walks the chain
// one cell per cycle, and a new packet is taken only once the previous result
// has moved from the register behind the chain into the output register. A
// miss allocates a free entry, or the round-robin victim once the table is
// full, when the token leaves the chain.
// A finished result waits in the output register while the next packet is
// already accepted and looked up; if the receiver stalls further, the next
// result is held in the register behind the chain and no more packets are
// taken.
// Reset empties the table (entry fill count zero), clears the replacement
// pointer, drops any transfer in flight and loads the register defaults.
// ----------------------------------------------------------------------------
module per_source_flood_detector #(
	parameter int MAX_SOURCES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// source_addr [31:0], time_us [79:32]
	input  logic [pfd_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// alert_source [31:0], alert_count [47:32], first_seen_us [95:48],
	// last_seen_us [143:96], span_us [192:144], zero [199:193]
	output logic [pfd_pkg::OUT_W-1:0] m_tdata,
	// alert [0]
	output logic                      m_tuser
);
	import pfd_pkg::*;

	localparam int N  = MAX_SOURCES;
	localparam int IW = $clog2(N);
	localparam int UW = $clog2(N + 1);

	cfg_t              cfg_q;
	logic [UW-1:0]     used_q;
	logic [IW-1:0]     rptr_q;
	logic              busy_q;

	tok_t              tok [0:N];
	tok_t              tail;
	logic [N-1:0]      active;
	logic [N-1:0]      wr_sel;
	wr_t               wr;
	logic [IW-1:0]     wr_idx;
	logic              full;

	logic              pend_valid_q;
	logic              pend_alert_q;
	logic [ADDR_W-1:0] pend_src_q;
	logic [CNT_W-1:0]  pend_cnt_q;
	logic [TIME_W-1:0] pend_first_q;
	logic [TIME_W-1:0] pend_last_q;

	logic              out_valid_q;
	logic              out_alert_q;
	logic [OUT_W-1:0]  out_data_q;

	logic              in_xfer;
	logic              miss_alert;
	logic              move;
	logic [SPAN_W-1:0] span;

	assign s_tready = !busy_q;
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_alert_q;

	assign tok[0] = {in_xfer, 1'b0, 1'b0, s_tdata[ADDR_W-1:0],
		s_tdata[ADDR_W+TIME_W-1:ADDR_W], {CNT_W{1'b0}}, {TIME_W{1'b0}}};

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			assign active[gi] = UW'(gi) < used_q;
			assign wr_sel[gi] = wr_idx == IW'(gi);
			pfd_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cfg     (cfg_q),
				.active  (active[gi]),
				.wr_sel  (wr_sel[gi]),
				.wr      (wr),
				.tok_in  (tok[gi]),
				.tok_out (tok[gi+1])
			);
		end
	endgenerate

	assign tail       = tok[N];
	assign full       = used_q == UW'(N);
	assign wr_idx     = full ? rptr_q : used_q[IW-1:0];
	assign miss_alert = cfg_q.thr <= CNT_W'(1);

	always_comb begin
		wr.en     = tail.valid && !tail.found;
		wr.src    = tail.src;
		wr.cnt    = miss_alert ? '0 : CNT_W'(1);
		wr.wstart = tail.ts;
	end

	assign move = pend_valid_q && (!out_valid_q || m_tready);
	assign span = {1'b0, pend_last_q} - {1'b0, pend_first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr    <= THR_RESET;
			cfg_q.win_us <= WIN_US_RESET;
			used_q       <= '0;
			rptr_q       <= '0;
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_ALERT_THRESHOLD: cfg_q.thr    <= cfg_data;
					REG_WINDOW_LENGTH_S: cfg_q.win_us <= WIN_W'(cfg_data) * WIN_W'(US_PER_S);
					default: ;
				endcase
			end
			if (wr.en) begin
				if (full) begin
					rptr_q <= (rptr_q == IW'(N - 1)) ? '0 : rptr_q + 1'b1;
				end else begin
					used_q <= used_q + 1'b1;
				end
			end
			if (in_xfer) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (tail.valid) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			pend_src_q  <= tail.src;
			pend_last_q <= tail.ts;
			if (tail.found) begin
				pend_alert_q <= tail.alert;
				pend_cnt_q   <= tail.cnt;
				pend_first_q <= tail.first;
			end else begin
				pend_alert_q <= miss_alert;
				pend_cnt_q   <= CNT_W'(1);
				pend_first_q <= tail.ts;
			end
		end
		if (move) begin
			out_alert_q <= pend_alert_q;
			if (pend_alert_q) begin
				out_data_q <= {7'b0, span, pend_last_q, pend_first_q, pend_cnt_q,
					pend_src_q};
			end else begin
				out_data_q <= '0;
			end
		end
	end

endmodule
